>>> design/cfmm_pkg.sv
// Shared types and constants for the circular FIFO with min/max query.
package cfmm_pkg;

	// Width of one stored word and of the reported occupancy.
	localparam int DATA_W = 32;
	localparam int OCC_W  = 3;

	// Request codes.
	localparam logic [1:0] REQ_PUSH  = 2'd0;
	localparam logic [1:0] REQ_POP   = 2'd1;
	localparam logic [1:0] REQ_CLEAR = 2'd2;
	localparam logic [1:0] REQ_QUERY = 2'd3;

	// Status codes.
	localparam logic [1:0] STAT_OK          = 2'd0;
	localparam logic [1:0] STAT_OVERFLOW    = 2'd1;
	localparam logic [1:0] STAT_UNDERFLOW   = 2'd2;
	localparam logic [1:0] STAT_EMPTY_QUERY = 2'd3;

	// Sequencer states.
	typedef enum logic [1:0] {
		S_IDLE,
		S_POP,
		S_SCAN,
		S_DONE
	} state_t;

endpackage

>>> design/cfmm_if.sv
// Request and response channel interfaces of the circular FIFO.
interface cfmm_req_if;
	import cfmm_pkg::*;

	logic                     valid;
	logic                     ready;
	logic [1:0]               req_type;
	logic signed [DATA_W-1:0] push_value;

	modport source (output valid, output req_type, output push_value, input ready);
	modport sink   (input valid, input req_type, input push_value, output ready);
endinterface

interface cfmm_rsp_if;
	import cfmm_pkg::*;

	logic                     valid;
	logic                     ready;
	logic [1:0]               status;
	logic signed [DATA_W-1:0] pop_value;
	logic signed [DATA_W-1:0] max_value;
	logic signed [DATA_W-1:0] min_value;
	logic [OCC_W-1:0]         occupancy;

	modport source (
		output valid, output status, output pop_value, output max_value,
		output min_value, output occupancy, input ready
	);
	modport sink (
		input valid, input status, input pop_value, input max_value,
		input min_value, input occupancy, output ready
	);
endinterface

>>> design/cfmm_ram.sv
// Generic single-write, single-read RAM with registered read data.
module cfmm_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 4
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// Write port.
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// Read port with output register.
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

>>> design/circular_fifo_min_max_core.sv
// A query reads the stored words one word per cycle through the single RAM read port.
// Throughput: one request at a time; the next word is accepted once the sequencer is back in idle,
// which it reaches as soon as the result enters the output register.
// Reset clears the pointers, the count, the sequencer and the response valid; the storage itself
// is not cleared, and a pop or query uses only words that were pushed.
module circular_fifo_min_max_core #(
	parameter int DEPTH = 4
) (
	input  logic       clk,
	input  logic       arst_n,
	cfmm_req_if.sink   req,
	cfmm_rsp_if.source rsp
);
	import cfmm_pkg::*;

	localparam int PTR_W = $clog2(DEPTH);
	localparam int CNT_W = $clog2(DEPTH + 1);

	state_t state_q, state_nxt;

	logic [PTR_W-1:0] head_q, tail_q, scan_ptr_q;
	logic [CNT_W-1:0] count_q, left_q;
	logic             first_q;

	logic [1:0]               res_status_q;
	logic signed [DATA_W-1:0] res_pop_q, max_q, min_q;

	logic                     rsp_valid_q;
	logic [1:0]               rsp_status_q;
	logic signed [DATA_W-1:0] rsp_pop_q, rsp_max_q, rsp_min_q;
	logic [OCC_W-1:0]         rsp_occ_q;

	logic             accept, is_empty, is_full, rsp_load;
	logic             ram_we, ram_re;
	logic [PTR_W-1:0] ram_raddr;
	logic [DATA_W-1:0] ram_rdata;
	logic signed [DATA_W-1:0] rd_word;

	// Ring pointer advance with wrap at the last entry.
	function automatic logic [PTR_W-1:0] ptr_next(input logic [PTR_W-1:0] p);
		logic [PTR_W-1:0] r;
		if (p == PTR_W'(DEPTH - 1)) begin
			r = '0;
		end else begin
			r = p + PTR_W'(1);
		end
		return r;
	endfunction

	assign is_empty = (count_q == '0);
	assign is_full  = (count_q == CNT_W'(DEPTH));
	assign accept   = req.valid && req.ready;
	assign rsp_load = (state_q == S_DONE) && (!rsp_valid_q || rsp.ready);
	assign rd_word  = $signed(ram_rdata);

	// Next-state logic of the sequencer.
	always_comb begin
		state_nxt = state_q;
		case (state_q)
			S_IDLE: begin
				if (accept) begin
					case (req.req_type)
						REQ_POP:   state_nxt = is_empty ? S_DONE : S_POP;
						REQ_QUERY: state_nxt = is_empty ? S_DONE : S_SCAN;
						default:   state_nxt = S_DONE;
					endcase
				end
			end
			S_POP:  state_nxt = S_DONE;
			S_SCAN: begin
				if (left_q == CNT_W'(1)) begin
					state_nxt = S_DONE;
				end
			end
			S_DONE: begin
				if (rsp_load) begin
					state_nxt = S_IDLE;
				end
			end
			default: state_nxt = S_IDLE;
		endcase
	end

	// Sequencer outputs: handshake and RAM port control.
	always_comb begin
		req.ready = 1'b0;
		ram_we    = 1'b0;
		ram_re    = 1'b0;
		ram_raddr = head_q;
		case (state_q)
			S_IDLE: begin
				req.ready = 1'b1;
				ram_we    = accept && (req.req_type == REQ_PUSH) && !is_full;
				ram_re    = accept && !is_empty
					&& ((req.req_type == REQ_POP) || (req.req_type == REQ_QUERY));
			end
			S_SCAN: begin
				ram_re    = 1'b1;
				ram_raddr = scan_ptr_q;
			end
			default: begin
				req.ready = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	// Queue pointers and count, updated when a request is accepted.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q  <= '0;
			tail_q  <= '0;
			count_q <= '0;
		end else if (accept) begin
			case (req.req_type)
				REQ_PUSH: begin
					if (!is_full) begin
						tail_q  <= ptr_next(tail_q);
						count_q <= count_q + CNT_W'(1);
					end
				end
				REQ_POP: begin
					if (!is_empty) begin
						head_q  <= ptr_next(head_q);
						count_q <= count_q - CNT_W'(1);
					end
				end
				REQ_CLEAR: begin
					head_q  <= '0;
					tail_q  <= '0;
					count_q <= '0;
				end
				default: begin
					count_q <= count_q;
				end
			endcase
		end
	end

	// Result staging: status at accept, popped word, and the min/max compare loop.
	always_ff @(posedge clk) begin
		if (accept) begin
			res_status_q <= STAT_OK;
			res_pop_q    <= '0;
			max_q        <= '0;
			min_q        <= '0;
			scan_ptr_q   <= ptr_next(head_q);
			left_q       <= count_q;
			first_q      <= 1'b1;
			case (req.req_type)
				REQ_PUSH:  if (is_full)  res_status_q <= STAT_OVERFLOW;
				REQ_POP:   if (is_empty) res_status_q <= STAT_UNDERFLOW;
				REQ_QUERY: if (is_empty) res_status_q <= STAT_EMPTY_QUERY;
				default:   res_status_q <= STAT_OK;
			endcase
		end else if (state_q == S_POP) begin
			res_pop_q <= rd_word;
		end else if (state_q == S_SCAN) begin
			// One stored word per cycle goes through the shared compare pair.
			first_q    <= 1'b0;
			left_q     <= left_q - CNT_W'(1);
			scan_ptr_q <= ptr_next(scan_ptr_q);
			if (first_q || (rd_word > max_q)) begin
				max_q <= rd_word;
			end
			if (first_q || (rd_word < min_q)) begin
				min_q <= rd_word;
			end
		end
	end

	// Output register: holds the word until the sink takes it.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (rsp_load) begin
			rsp_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (rsp_load) begin
			rsp_status_q <= res_status_q;
			rsp_pop_q    <= res_pop_q;
			rsp_max_q    <= max_q;
			rsp_min_q    <= min_q;
			rsp_occ_q    <= OCC_W'(count_q);
		end
	end

	assign rsp.valid     = rsp_valid_q;
	assign rsp.status    = rsp_status_q;
	assign rsp.pop_value = rsp_pop_q;
	assign rsp.max_value = rsp_max_q;
	assign rsp.min_value = rsp_min_q;
	assign rsp.occupancy = rsp_occ_q;

	// Entry storage.
	cfmm_ram #(
		.WIDTH(DATA_W),
		.DEPTH(DEPTH)
	) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (tail_q),
		.wdata (req.push_value),
		.re    (ram_re),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

endmodule

>>> sim/testbench.sv
// Self-checking testbench for the circular FIFO core with min/max query.
`timescale 1ns / 100ps

module testbench;
	import cfmm_pkg::*;

	localparam int DEPTH       = 4;
	localparam int CYCLE_LIMIT = 200000;
	localparam int RANDOM_WORDS = 1000;

	// One expected reply word.
	typedef struct {
		logic [1:0]               status;
		logic signed [DATA_W-1:0] pop_value;
		logic signed [DATA_W-1:0] max_value;
		logic signed [DATA_W-1:0] min_value;
		logic [OCC_W-1:0]         occupancy;
	} reply_t;

	// Shadow copy of the ring buffer that predicts every reply in order.
	class fifo_tracker;
		logic signed [DATA_W-1:0] slots[DEPTH];
		int     head;
		int     tail;
		int     count;
		int     errors;
		reply_t replies[$];

		function new();
			head   = 0;
			tail   = 0;
			count  = 0;
			errors = 0;
		endfunction

		function int pending();
			return replies.size();
		endfunction

		// Apply one accepted request to the shadow buffer and queue its reply.
		function void note_request(logic [1:0] kind, logic signed [DATA_W-1:0] value);
			reply_t r;
			int     idx;
			r.status    = STAT_OK;
			r.pop_value = '0;
			r.max_value = '0;
			r.min_value = '0;
			case (kind)
				REQ_PUSH: begin
					if (count >= DEPTH) begin
						r.status = STAT_OVERFLOW;
					end else begin
						slots[tail] = value;
						tail = (tail + 1) % DEPTH;
						count++;
					end
				end
				REQ_POP: begin
					if (count == 0) begin
						r.status = STAT_UNDERFLOW;
					end else begin
						r.pop_value = slots[head];
						head = (head + 1) % DEPTH;
						count--;
					end
				end
				REQ_CLEAR: begin
					head  = 0;
					tail  = 0;
					count = 0;
				end
				REQ_QUERY: begin
					if (count == 0) begin
						r.status = STAT_EMPTY_QUERY;
					end else begin
						// Scan from the oldest to the newest stored word.
						idx = head;
						r.max_value = slots[idx];
						r.min_value = slots[idx];
						for (int k = 1; k < count; k++) begin
							idx = (idx + 1) % DEPTH;
							if (slots[idx] > r.max_value) r.max_value = slots[idx];
							if (slots[idx] < r.min_value) r.min_value = slots[idx];
						end
					end
				end
			endcase
			r.occupancy = OCC_W'(count);
			replies.push_back(r);
		endfunction

		// Compare one accepted reply with the oldest expectation.
		function void check_reply(logic [1:0] status, logic signed [DATA_W-1:0] pop_value,
				logic signed [DATA_W-1:0] max_value, logic signed [DATA_W-1:0] min_value,
				logic [OCC_W-1:0] occupancy);
			reply_t r;
			if (replies.size() == 0) begin
				$error("reply word with no request outstanding");
				errors++;
				return;
			end
			r = replies.pop_front();
			if (status !== r.status) begin
				$error("status: expected %0d, got %0d", r.status, status);
				errors++;
			end
			if (pop_value !== r.pop_value) begin
				$error("pop_value: expected %0d, got %0d", r.pop_value, pop_value);
				errors++;
			end
			if (max_value !== r.max_value) begin
				$error("max_value: expected %0d, got %0d", r.max_value, max_value);
				errors++;
			end
			if (min_value !== r.min_value) begin
				$error("min_value: expected %0d, got %0d", r.min_value, min_value);
				errors++;
			end
			if (occupancy !== r.occupancy) begin
				$error("occupancy: expected %0d, got %0d", r.occupancy, occupancy);
				errors++;
			end
		endfunction
	endclass

	logic        clk = 1'b0;
	logic        arst_n;
	int          cycles = 0;
	int          req_calm = 0;
	int          rsp_calm = 0;
	fifo_tracker tracker;

	cfmm_req_if req_ch ();
	cfmm_rsp_if rsp_ch ();

	circular_fifo_min_max_core #(
		.DEPTH(DEPTH)
	) i_dut (
		.clk   (clk),
		.arst_n(arst_n),
		.req   (req_ch),
		.rsp   (rsp_ch)
	);

	// Clock with a 12 ns period.
	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// Watchdog on the total run length.
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("DONE: errors detected");
			$finish;
		end
	end

	// Idle cycles before a word, with occasional stretches of back-to-back traffic.
	function automatic int draw_gap(inout int calm_left);
		if (calm_left > 0) begin
			calm_left--;
			return 0;
		end
		if ($urandom_range(0, 15) == 0) calm_left = 20;
		return $urandom_range(0, 5);
	endfunction

	// Request mix: push and pop weights in percent, query fills most of the rest.
	function automatic logic [1:0] pick_kind(int push_w, int pop_w);
		int roll;
		roll = $urandom_range(0, 99);
		if (roll < push_w) return REQ_PUSH;
		if (roll < push_w + pop_w) return REQ_POP;
		if (roll < 95) return REQ_QUERY;
		return REQ_CLEAR;
	endfunction

	// Values lean toward the signed extremes and near-zero to make ties and sign flips common.
	function automatic logic signed [DATA_W-1:0] pick_value();
		case ($urandom_range(0, 9))
			0: return {1'b1, {(DATA_W-1){1'b0}}};
			1: return {1'b0, {(DATA_W-1){1'b1}}};
			2, 3: return DATA_W'($signed($urandom_range(0, 20)) - 10);
			default: return $urandom;
		endcase
	endfunction

	// Present one request word and hold it until the core takes it.
	task automatic send_request(logic [1:0] kind, logic signed [DATA_W-1:0] value);
		int gap;
		gap = draw_gap(req_calm);
		if (gap > 0) begin
			req_ch.valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		req_ch.valid      <= 1'b1;
		req_ch.req_type   <= kind;
		req_ch.push_value <= value;
		do @(posedge clk); while (!req_ch.ready);
		tracker.note_request(kind, value);
		@(negedge clk);
	endtask

	// Reply side: random back-pressure, every accepted word checked.
	initial begin
		int stall;
		rsp_ch.ready = 1'b0;
		@(posedge arst_n);
		@(negedge clk);
		forever begin
			stall = draw_gap(rsp_calm);
			if (stall > 0) begin
				rsp_ch.ready <= 1'b0;
				repeat (stall) @(negedge clk);
			end
			rsp_ch.ready <= 1'b1;
			do @(posedge clk); while (!rsp_ch.valid);
			tracker.check_reply(rsp_ch.status, rsp_ch.pop_value, rsp_ch.max_value,
				rsp_ch.min_value, rsp_ch.occupancy);
			@(negedge clk);
		end
	end

	// Main sequence: reset, directed cases, random traffic, drain.
	initial begin
		int push_w;
		int pop_w;
		tracker           = new();
		arst_n            = 1'b0;
		req_ch.valid      = 1'b0;
		req_ch.req_type   = REQ_PUSH;
		req_ch.push_value = '0;
		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// Empty queue: query and pop are both refused.
		send_request(REQ_QUERY, '0);
		send_request(REQ_POP, '1);
		// Fill with the extremes, then overflow.
		send_request(REQ_PUSH, {1'b1, {(DATA_W-1){1'b0}}});
		send_request(REQ_PUSH, {1'b0, {(DATA_W-1){1'b1}}});
		send_request(REQ_PUSH, '1);
		send_request(REQ_PUSH, '0);
		send_request(REQ_PUSH, 32'sd12345);
		send_request(REQ_QUERY, '0);
		// Drain completely, then underflow.
		send_request(REQ_POP, '0);
		send_request(REQ_QUERY, '0);
		send_request(REQ_POP, '0);
		send_request(REQ_POP, '0);
		send_request(REQ_POP, '0);
		send_request(REQ_POP, '0);
		// Pushing after the last pop must work from empty again.
		send_request(REQ_PUSH, 32'sd7);
		send_request(REQ_QUERY, '0);
		send_request(REQ_PUSH, -32'sd7);
		send_request(REQ_QUERY, '0);
		// Clear, then check the queue behaves as empty.
		send_request(REQ_CLEAR, '1);
		send_request(REQ_QUERY, '0);
		send_request(REQ_POP, '0);
		send_request(REQ_PUSH, 32'sd5);
		send_request(REQ_POP, '0);

		// Random traffic in phases that lean toward filling, draining or balance.
		push_w = 40;
		pop_w  = 30;
		for (int n = 0; n < RANDOM_WORDS; n++) begin
			if (n % 40 == 0) begin
				case ($urandom_range(0, 2))
					0: begin push_w = 60; pop_w = 15; end
					1: begin push_w = 20; pop_w = 50; end
					default: begin push_w = 40; pop_w = 30; end
				endcase
			end
			send_request(pick_kind(push_w, pop_w), pick_value());
		end
		req_ch.valid <= 1'b0;

		// Wait for every outstanding reply, then keep watching for strays.
		while (tracker.pending() != 0) @(posedge clk);
		repeat (20) @(posedge clk);
		if (tracker.errors == 0) begin
			$display("DONE: 0 errors");
		end else begin
			$display("DONE: errors detected");
		end
		$finish;
	end

endmodule

>>> filelist.f
design/cfmm_pkg.sv
design/cfmm_if.sv
design/cfmm_ram.sv
design/circular_fifo_min_max_core.sv
sim/testbench.sv
